/* hw/rtl/eqd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equirectangular distance package
// Shared constants, stage map and helper function for the distance pipeline.
// ----------------------------------------------------------------------------
package eqd_pkg;

    // Result ceiling in sixteenths of a metre.
    localparam logic [29:0] DIST_MAX     = 30'd716100000;
    // Per-axis ceiling in quarter-output units (four times the result ceiling).
    localparam logic [31:0] SAT_LIMIT    = 32'd2864400000;
    // Ninety and one hundred and eighty degrees in 2^-23 degree units.
    localparam logic [30:0] QUARTER_TURN = 31'd754974720;
    localparam logic [30:0] HALF_TURN    = 31'd1509949440;
    // pi / 180 in Q32.
    localparam logic [26:0] DEG2RAD_Q32  = 27'd74961321;
    // Degrees (Q22) to sixteenths of a metre on the earth sphere, in Q32.
    localparam logic [30:0] SCALE_Q32    = 31'd1821817678;
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;

    // Horner evaluation of the cosine series, one term per step.
    localparam int unsigned HORNER_TERMS = 7;
    localparam int unsigned HORNER_DIV [HORNER_TERMS] = '{182, 132, 90, 56, 30, 12, 2};
    // Reciprocal multipliers: floor(2^(32+s)/d)+1 with 2^s >= d, exact for 32-bit numerators.
    localparam int unsigned HORNER_SHIFT [HORNER_TERMS] = '{8, 8, 7, 6, 5, 4, 1};
    localparam logic [32:0] HORNER_RECIP [HORNER_TERMS] = '{
        33'd6041272681, 33'd8329633544, 33'd6108397933, 33'd4908534053,
        33'd4581298450, 33'd5726623062, 33'd4294967297
    };

    // Stage map of the whole pipeline.
    localparam int unsigned COS_FIRST   = 3;
    localparam int unsigned COS_STAGES  = 2 * HORNER_TERMS;
    localparam int unsigned X_STAGE     = COS_FIRST + COS_STAGES;
    localparam int unsigned SQRT_FIRST  = X_STAGE + 5;
    localparam int unsigned SQRT_STAGES = 16;
    localparam int unsigned OUT_STAGE   = SQRT_FIRST + SQRT_STAGES;
    localparam int unsigned NUM_STAGES  = OUT_STAGE + 1;

    // One minus a Horner quotient in Q30, clamped at zero.
    function automatic logic [30:0] one_minus_clamp(input logic [31:0] quot);
        logic [31:0] diff;
        diff = {1'b0, ONE_Q30} - quot;
        if (quot >= {1'b0, ONE_Q30})
        begin
            return 31'd0;
        end
        return diff[30:0];
    endfunction

endpackage

/* hw/rtl/eqd_cos_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine series pipeline
// Horner steps of the |cos| series, a product stage and a division stage each.
// ----------------------------------------------------------------------------
module eqd_cos_pipe
    import eqd_pkg::*;
(
    input  logic                  clk,
    input  logic [COS_STAGES-1:0] en,
    input  logic [31:0]           t_sq,
    output logic [31:0]           quot
);

    logic [31:0] t_a_reg    [HORNER_TERMS-1];
    logic [31:0] t_b_reg    [HORNER_TERMS-1];
    logic [31:0] prod_reg   [HORNER_TERMS];
    logic [31:0] quot_reg   [HORNER_TERMS];

    for (genvar i = 0; i < HORNER_TERMS; i++)
    begin : g_term
        localparam logic [31:0] HALF_DIV = 32'(HORNER_DIV[i] / 2);
        logic [31:0] t_src;
        logic [30:0] h_src;
        logic [62:0] p_prod;
        logic [63:0] p_sum;
        logic [31:0] numer;
        logic [64:0] q_prod;
        logic [64:0] q_shift;

        if (i == 0)
        begin : g_first
            assign t_src = t_sq;
            assign h_src = ONE_Q30;
        end
        else
        begin : g_rest
            assign t_src = t_b_reg[i-1];
            assign h_src = one_minus_clamp(quot_reg[i-1]);
        end

        assign p_prod  = t_src * h_src;
        assign p_sum   = {1'b0, p_prod} + (64'd1 << 29);
        assign numer   = prod_reg[i] + HALF_DIV;
        assign q_prod  = numer * HORNER_RECIP[i];
        assign q_shift = q_prod >> (32 + HORNER_SHIFT[i]);

        always_ff @(posedge clk)
        begin
            if (en[2*i])
            begin
                prod_reg[i] <= p_sum[61:30];
            end
            if (en[2*i+1])
            begin
                quot_reg[i] <= q_shift[31:0];
            end
        end

        // The series argument follows the item only while later terms need it.
        if (i < HORNER_TERMS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[2*i])
                begin
                    t_a_reg[i] <= t_src;
                end
                if (en[2*i+1])
                begin
                    t_b_reg[i] <= t_a_reg[i];
                end
            end
        end
    end

    assign quot = quot_reg[HORNER_TERMS-1];

endmodule

/* hw/rtl/eqd_isqrt_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root pipeline
// Digit-by-digit root of a 64-bit value, two root bits per stage.
// ----------------------------------------------------------------------------
module eqd_isqrt_pipe
    import eqd_pkg::*;
(
    input  logic                   clk,
    input  logic [SQRT_STAGES-1:0] en,
    input  logic [63:0]            radicand,
    output logic [31:0]            root,
    output logic [33:0]            rem
);

    typedef struct packed {
        logic [31:0] root;
        logic [33:0] rem;
        logic [63:0] bits;
    } root_t;

    function automatic root_t root_step(input root_t cur);
        logic [35:0] acc;
        logic [35:0] trial;
        logic [35:0] diff;
        root_t       nxt;
        acc      = {cur.rem, cur.bits[63:62]};
        trial    = {2'b00, cur.root, 2'b01};
        diff     = acc - trial;
        nxt.bits = {cur.bits[61:0], 2'b00};
        if (acc >= trial)
        begin
            nxt.rem  = diff[33:0];
            nxt.root = {cur.root[30:0], 1'b1};
        end
        else
        begin
            nxt.rem  = acc[33:0];
            nxt.root = {cur.root[30:0], 1'b0};
        end
        return nxt;
    endfunction

    root_t stage_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        root_t src;
        root_t mid;
        root_t nxt;

        if (k == 0)
        begin : g_first
            assign src = '{root: 32'd0, rem: 34'd0, bits: radicand};
        end
        else
        begin : g_rest
            assign src = stage_reg[k-1];
        end

        assign mid = root_step(src);
        assign nxt = root_step(mid);

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                stage_reg[k] <= nxt;
            end
        end
    end

    assign root = stage_reg[SQRT_STAGES-1].root;
    assign rem  = stage_reg[SQRT_STAGES-1].rem;

endmodule

/* hw/rtl/equirectangular_distance_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equirectangular distance unit
// Approximate great-circle distance between two points, one request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Each request carries two points in signed degrees with 2^-22 degree per LSB
// and returns the equirectangular distance between them in sixteenths of a
// metre, saturated at 716100000. The unit is a 39-stage pipeline: one request
// is taken in every cycle while the output side keeps up. Every stage has its
// own valid bit and moves whenever it is empty or the stage after it moves,
// so a stalled output only holds the stages that are full and bubbles are
// squeezed out before the input side is held. The depth is set by the seven
// Horner steps of the cosine series (a product and a reciprocal division
// stage each) and by the square root, which resolves two root bits per
// stage over sixteen stages.
// ----------------------------------------------------------------------------
module equirectangular_distance_unit
    import eqd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: [29:0] first_latitude, [60:30] first_longitude,
    //          [90:61] second_latitude, [121:91] second_longitude, rest zero
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: [29:0] distance, rest zero
    output logic [31:0]  m_tdata
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    // A stage moves when it is empty or when the stage after it moves.
    assign en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
    for (genvar g = 0; g < NUM_STAGES - 1; g++)
    begin : g_enable
        assign en[g] = !valid_reg[g] || en[g+1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];

    // ---------------------------------------------------------------- stage 0
    // Differences, and the magnitude of the latitude sum (twice the mean)
    // folded about ninety degrees, since only the size of the cosine counts.
    logic [29:0] lat1;
    logic [30:0] lon1;
    logic [29:0] lat2;
    logic [30:0] lon2;
    logic [30:0] lat_diff;
    logic [30:0] lat_sum;
    logic [31:0] lon_diff;
    logic [30:0] mean_mag;
    logic [30:0] folded;
    logic [30:0] dlat;
    logic [31:0] dlon;
    logic [29:0] angle;

    assign lat1 = s_tdata[29:0];
    assign lon1 = s_tdata[60:30];
    assign lat2 = s_tdata[90:61];
    assign lon2 = s_tdata[121:91];

    assign lat_diff = {lat2[29], lat2} - {lat1[29], lat1};
    assign lat_sum  = {lat1[29], lat1} + {lat2[29], lat2};
    assign lon_diff = {lon2[30], lon2} - {lon1[30], lon1};
    assign dlat     = lat_diff[30] ? (31'd0 - lat_diff) : lat_diff;
    assign dlon     = lon_diff[31] ? (32'd0 - lon_diff) : lon_diff;
    assign mean_mag = lat_sum[30] ? (31'd0 - lat_sum) : lat_sum;
    assign folded   = HALF_TURN - mean_mag;
    assign angle    = (mean_mag > QUARTER_TURN) ? folded[29:0] : mean_mag[29:0];

    logic [30:0] dlat_reg  [X_STAGE];
    logic [31:0] dlon_reg  [X_STAGE];
    logic [29:0] angle_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dlat_reg[0] <= dlat;
            dlon_reg[0] <= dlon;
            angle_reg   <= angle;
        end
    end

    // The differences ride along until the cosine is ready.
    for (genvar g = 1; g < X_STAGE; g++)
    begin : g_delta_line
        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                dlat_reg[g] <= dlat_reg[g-1];
                dlon_reg[g] <= dlon_reg[g-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Angle to radians in Q30.
    logic [56:0] rad_prod;
    logic [57:0] rad_sum;
    logic [30:0] rad_reg;

    assign rad_prod = angle_reg * DEG2RAD_Q32;
    assign rad_sum  = {1'b0, rad_prod} + (58'd1 << 24);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rad_reg <= rad_sum[55:25];
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Square of the angle, the argument of the Horner series.
    logic [61:0] sq_prod;
    logic [62:0] sq_sum;
    logic [31:0] t_reg;

    assign sq_prod = rad_reg * rad_reg;
    assign sq_sum  = {1'b0, sq_prod} + (63'd1 << 29);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            t_reg <= sq_sum[61:30];
        end
    end

    // ------------------------------------------------------ cosine stages
    logic [31:0] cos_quot;

    eqd_cos_pipe u_cos
    (
        .clk  (clk),
        .en   (en[X_STAGE-1:COS_FIRST]),
        .t_sq (t_reg),
        .quot (cos_quot)
    );

    // ------------------------------------------------------------- x stage
    // Longitude difference scaled by |cos|; latitude difference to output units.
    logic [30:0] cos_mag;
    logic [62:0] x_prod;
    logic [63:0] x_sum;
    logic [61:0] y_prod;
    logic [62:0] y_sum;
    logic [33:0] x_reg;
    logic [31:0] yo_reg [X_STAGE:X_STAGE+2];

    assign cos_mag = one_minus_clamp(cos_quot);
    assign x_prod  = dlon_reg[X_STAGE-1] * cos_mag;
    assign x_sum   = {1'b0, x_prod} + (64'd1 << 27);
    assign y_prod  = dlat_reg[X_STAGE-1] * SCALE_Q32;
    assign y_sum   = {1'b0, y_prod} + (63'd1 << 29);

    always_ff @(posedge clk)
    begin
        if (en[X_STAGE])
        begin
            x_reg              <= x_sum[61:28];
            yo_reg[X_STAGE]    <= y_sum[61:30];
        end
    end

    // The x scaling is split into two partial products of the 34-bit value.
    logic [47:0] xlo_reg;
    logic [47:0] xhi_reg;

    always_ff @(posedge clk)
    begin
        if (en[X_STAGE+1])
        begin
            xlo_reg             <= x_reg[16:0] * SCALE_Q32;
            xhi_reg             <= x_reg[33:17] * SCALE_Q32;
            yo_reg[X_STAGE+1]   <= yo_reg[X_STAGE];
        end
    end

    // Partial products are combined and both axes are checked against the ceiling.
    logic [65:0] xo_full;
    logic [33:0] xo;
    logic        sat_now;
    logic [31:0] xo_reg;
    logic [OUT_STAGE-1:X_STAGE+2] sat_reg;

    assign xo_full = {1'b0, xhi_reg, 17'd0} + {18'd0, xlo_reg} + (66'd1 << 31);
    assign xo      = xo_full[65:32];
    assign sat_now = (xo > {2'b00, SAT_LIMIT}) || (yo_reg[X_STAGE+1] > SAT_LIMIT);

    always_ff @(posedge clk)
    begin
        if (en[X_STAGE+2])
        begin
            xo_reg              <= xo[31:0];
            yo_reg[X_STAGE+2]   <= yo_reg[X_STAGE+1];
            sat_reg[X_STAGE+2]  <= sat_now;
        end
    end

    // Squares of both axes, then their sum.
    logic [63:0] xsq_reg;
    logic [63:0] ysq_reg;
    logic [64:0] sq_total;
    logic [63:0] radicand_reg;

    assign sq_total = {1'b0, xsq_reg} + {1'b0, ysq_reg};

    always_ff @(posedge clk)
    begin
        if (en[X_STAGE+3])
        begin
            xsq_reg <= xo_reg * xo_reg;
            ysq_reg <= yo_reg[X_STAGE+2] * yo_reg[X_STAGE+2];
        end
        if (en[X_STAGE+4])
        begin
            radicand_reg <= sq_total[63:0];
        end
    end

    // The saturation flag follows the item through the root stages.
    for (genvar g = X_STAGE + 3; g < OUT_STAGE; g++)
    begin : g_sat_line
        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                sat_reg[g] <= sat_reg[g-1];
            end
        end
    end

    // ------------------------------------------------------- root stages
    logic [31:0] root;
    logic [33:0] root_rem;

    eqd_isqrt_pipe u_isqrt
    (
        .clk      (clk),
        .en       (en[OUT_STAGE-1:SQRT_FIRST]),
        .radicand (radicand_reg),
        .root     (root),
        .rem      (root_rem)
    );

    // ------------------------------------------------------ output stage
    // Round the root to nearest, drop the two quarter bits, then saturate.
    logic [32:0] root_near;
    logic [33:0] dist_sum;
    logic [30:0] dist_wide;
    logic [29:0] dist_next;
    logic [29:0] dist_reg;

    assign root_near = {1'b0, root} + {32'd0, (root_rem > {2'b00, root})};
    assign dist_sum  = {1'b0, root_near} + 34'd2;
    assign dist_wide = dist_sum[32:2];
    assign dist_next = (sat_reg[OUT_STAGE-1] || (dist_wide > {1'b0, DIST_MAX})) ?
                       DIST_MAX : dist_wide[29:0];

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
        begin
            dist_reg <= dist_next;
        end
    end

    assign m_tvalid = valid_reg[OUT_STAGE];
    assign m_tdata  = {2'b00, dist_reg};

    // ---------------------------------------------------------- assertions
    // A result never exceeds the ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[29:0] <= DIST_MAX))
        else $error("distance above ceiling");

    // The input side is only held once every stage is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg))
        else $error("input held while the pipeline has a bubble");

    // An accepted request occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted request lost at entry");

    // A saturated item leaves with the ceiling value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[OUT_STAGE-1] && sat_reg[OUT_STAGE-1] && en[OUT_STAGE])
        |=> (m_tdata[29:0] == DIST_MAX))
        else $error("saturated item not clamped");

endmodule
